@@ hw/rtl/http_chunked_body_decoder_core_defines.svh @@
// Assertion macros used by the chunked body decoder RTL (chbd_back).
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/chbd_pkg.sv @@
`timescale 1ns / 1ps

package chbd_pkg;

	localparam int LEN_BITS_DEFAULT = 32;
	localparam int CFG_W = 12;
	localparam logic [CFG_W-1:0] MAX_LINE_RESET = 12'd2048;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_TOO_LONG = 2'd2,
		KIND_OVERFLOW = 2'd3
	} result_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       is_cr;
		logic       is_lf;
		logic       is_blank;
		logic       is_hex;
		logic       is_zero;
		logic       is_x;
		logic [3:0] hex_val;
	} chbd_item_t;

endpackage

@@ hw/rtl/chbd_ifs.sv @@
`timescale 1ns / 1ps

interface chbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_body;

	modport source (output valid, output in_byte, output start_body, input ready);
	modport sink (input valid, input in_byte, input start_body, output ready);
endinterface

interface chbd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] data_byte;
	logic       chunk_last;

	modport source (output valid, output result_kind, output data_byte, output chunk_last,
		input ready);
	modport sink (input valid, input result_kind, input data_byte, input chunk_last,
		output ready);
endinterface

@@ hw/rtl/http_chunked_body_decoder_core.sv @@
`timescale 1ns / 1ps
// Channel  Role    Transfer holds
// in_ch    sink    in_byte, start_body
// out_ch   source  result_kind, data_byte, chunk_last
// cfg      write   cfg_wdata (max_size_line_len) on cfg_we
//
// One byte is taken per cycle while the queue has room; the parser state machine retires
// one queued byte per cycle unless the output is stalled. Results pass the two-entry
// queue, then the output register; the queue lets input continue while the output waits.
// arst_n clears the parser to a fresh size line and the line limit to 2048.
module http_chunked_body_decoder_core #(
	parameter int LEN_BITS = chbd_pkg::LEN_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	chbd_in_if.sink                    in_ch,
	chbd_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [chbd_pkg::CFG_W-1:0] cfg_wdata
);
	import chbd_pkg::*;

	chbd_item_t front_item;
	logic       front_push;
	logic       queue_room;
	chbd_item_t head_item;
	logic       head_valid;
	logic       head_pop;

	chbd_front u_front (
		.in_ch (in_ch),
		.room  (queue_room),
		.item  (front_item),
		.push  (front_push)
	);

	chbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push       (front_push),
		.room       (queue_room),
		.head_item  (head_item),
		.head_valid (head_valid),
		.pop        (head_pop)
	);

	chbd_back #(
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item       (head_item),
		.item_valid (head_valid),
		.item_pop   (head_pop),
		.out_ch     (out_ch)
	);

endmodule

@@ hw/rtl/chbd_front.sv @@
`timescale 1ns / 1ps

module chbd_front (
	chbd_in_if.sink            in_ch,
	input  logic               room,
	output chbd_pkg::chbd_item_t item,
	output logic               push
);
	import chbd_pkg::*;

	logic [7:0] c;
	logic       is_dec;
	logic       is_lo;
	logic       is_up;

	assign c = in_ch.in_byte;
	assign in_ch.ready = room;
	assign push = in_ch.valid & room;

	assign is_dec = (c >= 8'h30) && (c <= 8'h39);
	assign is_lo  = (c >= 8'h61) && (c <= 8'h66);
	assign is_up  = (c >= 8'h41) && (c <= 8'h46);

	always_comb begin
		item.data     = c;
		item.start    = in_ch.start_body;
		item.is_cr    = (c == CH_CR);
		item.is_lf    = (c == CH_LF);
		item.is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
		item.is_hex   = is_dec || is_lo || is_up;
		item.is_zero  = (c == 8'h30);
		item.is_x     = (c == 8'h78) || (c == 8'h58);
		if (is_dec) begin
			item.hex_val = c[3:0];
		end else if (is_lo || is_up) begin
			item.hex_val = c[3:0] + 4'd9;
		end else begin
			item.hex_val = 4'd0;
		end
	end

endmodule

@@ hw/rtl/chbd_queue.sv @@
`timescale 1ns / 1ps

module chbd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chbd_pkg::chbd_item_t push_item,
	input  logic                 push,
	output logic                 room,
	output chbd_pkg::chbd_item_t head_item,
	output logic                 head_valid,
	input  logic                 pop
);
	import chbd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	chbd_item_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_pop;

	assign room       = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/chbd_back.sv @@
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_core_defines.svh"

module chbd_back #(
	parameter int LEN_BITS = chbd_pkg::LEN_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [chbd_pkg::CFG_W-1:0] cfg_wdata,
	input  chbd_pkg::chbd_item_t       item,
	input  logic                       item_valid,
	output logic                       item_pop,
	chbd_out_if.source                 out_ch
);
	import chbd_pkg::*;

	typedef enum logic [6:0] {
		PH_BLANK   = 7'b0000001,
		PH_DIGITS  = 7'b0000010,
		PH_IGNORE  = 7'b0000100,
		PH_DATA    = 7'b0001000,
		PH_SKIP    = 7'b0010000,
		PH_TRAILER = 7'b0100000,
		PH_HALT    = 7'b1000000
	} phase_t;

	phase_t              phase_q, phase_d, ph;
	logic [CFG_W-1:0]    max_len_q;
	logic [CFG_W-1:0]    count_q, count_d, cnt;
	logic [LEN_BITS-1:0] accum_q, accum_d, acc;
	logic [LEN_BITS-1:0] left_q, left_d, left_dec;
	logic                prefix_q, prefix_d, pfx;
	logic                trailer_q, trailer_d, trl;

	logic                emit;
	result_kind_t        kind_d;
	logic [7:0]          data_d;
	logic                last_d;

	logic                out_valid_q;
	result_kind_t        out_kind_q;
	logic [7:0]          out_data_q;
	logic                out_last_q;

	assign item_pop = item_valid && (!out_valid_q || out_ch.ready);
	assign left_dec = left_q - LEN_BITS'(1);

	always_comb begin
		ph  = item.start ? PH_BLANK : phase_q;
		cnt = item.start ? '0 : count_q;
		acc = item.start ? '0 : accum_q;
		pfx = item.start ? 1'b0 : prefix_q;
		trl = item.start ? 1'b0 : trailer_q;

		phase_d   = ph;
		count_d   = cnt;
		accum_d   = acc;
		prefix_d  = pfx;
		trailer_d = trl;
		left_d    = item.start ? '0 : left_q;
		emit      = 1'b0;
		kind_d    = KIND_DATA;
		data_d    = 8'd0;
		last_d    = 1'b0;

		unique case (ph) inside
			PH_BLANK, PH_DIGITS, PH_IGNORE: begin
				if (item.is_cr) begin
					phase_d = ph;
				end else if (item.is_lf) begin
					if (acc == '0) begin
						phase_d   = PH_TRAILER;
						trailer_d = 1'b0;
					end else begin
						left_d  = acc;
						phase_d = PH_DATA;
					end
				end else if (cnt >= max_len_q) begin
					phase_d = PH_HALT;
					emit    = 1'b1;
					kind_d  = KIND_TOO_LONG;
				end else begin
					count_d = cnt + CFG_W'(1);
					if (ph == PH_BLANK) begin
						if (item.is_blank) begin
							phase_d = PH_BLANK;
						end else if (!item.is_hex) begin
							phase_d = PH_IGNORE;
						end else begin
							accum_d  = LEN_BITS'(item.hex_val);
							prefix_d = item.is_zero;
							phase_d  = PH_DIGITS;
						end
					end else if (ph == PH_DIGITS) begin
						if (item.is_hex) begin
							if (acc[LEN_BITS-1 -: 4] != 4'd0) begin
								phase_d = PH_HALT;
								emit    = 1'b1;
								kind_d  = KIND_OVERFLOW;
							end else begin
								accum_d  = {acc[LEN_BITS-5:0], item.hex_val};
								prefix_d = 1'b0;
							end
						end else if (item.is_x && pfx) begin
							prefix_d = 1'b0;
						end else begin
							phase_d = PH_IGNORE;
						end
					end
				end
			end
			PH_DATA: begin
				left_d = left_dec;
				emit   = 1'b1;
				data_d = item.data;
				if (left_dec == '0) begin
					last_d  = 1'b1;
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (item.is_lf) begin
					phase_d  = PH_BLANK;
					count_d  = '0;
					accum_d  = '0;
					prefix_d = 1'b0;
				end
			end
			PH_TRAILER: begin
				if (item.is_lf) begin
					if (!trl) begin
						phase_d = PH_HALT;
						emit    = 1'b1;
						kind_d  = KIND_COMPLETE;
					end else begin
						trailer_d = 1'b0;
					end
				end else if (!item.is_cr) begin
					trailer_d = 1'b1;
				end
			end
			PH_HALT: begin
				phase_d = PH_HALT;
			end
			default: begin
				phase_d = ph;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LINE_RESET;
			phase_q   <= PH_BLANK;
			count_q   <= '0;
			accum_q   <= '0;
			left_q    <= '0;
			prefix_q  <= 1'b0;
			trailer_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (item_pop) begin
				phase_q   <= phase_d;
				count_q   <= count_d;
				accum_q   <= accum_d;
				left_q    <= left_d;
				prefix_q  <= prefix_d;
				trailer_q <= trailer_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && emit) begin
			out_kind_q <= kind_d;
			out_data_q <= data_d;
			out_last_q <= last_d;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = out_kind_q;
	assign out_ch.data_byte   = out_data_q;
	assign out_ch.chunk_last  = out_last_q;

	`CHBD_ASSERT_IMPL(a_status_clean, clk, arst_n, out_valid_q && (out_kind_q != KIND_DATA), (out_data_q == 8'd0) && !out_last_q, "Status result carries payload bits.")
	`CHBD_ASSERT_IMPL(a_data_left, clk, arst_n, phase_q == PH_DATA, left_q != '0, "Chunk data phase with no bytes left.")
	`CHBD_ASSERT_NEXT(a_halt_after_status, clk, arst_n, item_pop && emit && (kind_d != KIND_DATA), phase_q == PH_HALT, "Status result did not halt the parser.")
	`CHBD_ASSERT_NEXT(a_skip_after_last, clk, arst_n, item_pop && emit && last_d, phase_q == PH_SKIP, "Last chunk byte did not end the data phase.")

endmodule

@@ dv/http_chunked_body_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module http_chunked_body_decoder_core_tb;
	import chbd_pkg::*;

	localparam int SIZE_BITS = LEN_BITS_DEFAULT;
	localparam int DRAIN_CYCLES = 6;
	localparam int DRAIN_GUARD = 20000;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;

	typedef enum logic [2:0] {
		ST_LEAD, ST_HEX, ST_EXT, ST_PAYLOAD, ST_TAIL, ST_TRAILER, ST_DONE
	} parse_state_t;

	typedef enum logic [1:0] {
		PFX_NONE, PFX_ZERO, PFX_X
	} hex_prefix_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   data_byte;
		logic         chunk_last;
	} decoded_t;

	typedef struct packed {
		logic [7:0] value;
		logic       start;
	} body_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	chbd_in_if in_ch();
	chbd_out_if out_ch();

	http_chunked_body_decoder_core #(
		.LEN_BITS(SIZE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	parse_state_t parse_state;
	hex_prefix_t hex_prefix;
	logic [11:0] line_bytes;
	logic [SIZE_BITS-1:0] size_acc;
	logic [SIZE_BITS-1:0] data_remaining;
	logic trailer_text;
	logic [CFG_W-1:0] line_limit;

	decoded_t pending_results[$];
	body_byte_t stream[$];
	int failures = 0;
	int src_idle_pct = 26;
	int snk_idle_pct = 57;
	int hold_request = 0;
	int hold_left = 0;

	always #1 clk = ~clk;

	function void clear_size_line();
		parse_state = ST_LEAD;
		line_bytes = '0;
		size_acc = '0;
		hex_prefix = PFX_NONE;
	endfunction

	function void reset_decoder_model();
		line_limit = MAX_LINE_RESET;
		clear_size_line();
		data_remaining = '0;
		trailer_text = 1'b0;
	endfunction

	function void push_result(result_kind_t kind, logic [7:0] data, logic last);
		decoded_t r;
		r.kind = kind;
		r.data_byte = data;
		r.chunk_last = last;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function void hex_digit(input logic [7:0] c, output logic ok, output logic [3:0] nib);
		ok = 1'b1;
		nib = 4'd0;
		if (c >= "0" && c <= "9") nib = 4'(c - "0");
		else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
		else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
		else ok = 1'b0;
	endfunction

	function void decode_byte(input logic [7:0] c, input logic start);
		logic is_hex;
		logic [3:0] nib;
		logic is_blank;
		hex_digit(c, is_hex, nib);
		is_blank = (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF);
		if (start) begin
			clear_size_line();
			data_remaining = '0;
			trailer_text = 1'b0;
		end
		case (parse_state)
			ST_LEAD, ST_HEX, ST_EXT: begin
				if (c == CH_LF) begin
					if (size_acc == 0) begin
						parse_state = ST_TRAILER;
						trailer_text = 1'b0;
					end else begin
						data_remaining = size_acc;
						parse_state = ST_PAYLOAD;
					end
				end else if (c != CH_CR) begin
					if ({1'b0, line_bytes} + 13'd1 > {1'b0, line_limit}) begin
						parse_state = ST_DONE;
						push_result(KIND_TOO_LONG, 8'h00, 1'b0);
					end else begin
						line_bytes = line_bytes + 12'd1;
						if (parse_state == ST_LEAD) begin
							if (!is_blank) begin
								if (!is_hex) begin
									parse_state = ST_EXT;
								end else begin
									size_acc = SIZE_BITS'(nib);
									hex_prefix = (c == CH_ZERO) ? PFX_ZERO : PFX_NONE;
									parse_state = ST_HEX;
								end
							end
						end else if (parse_state == ST_HEX) begin
							if (is_hex) begin
								if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
									parse_state = ST_DONE;
									push_result(KIND_OVERFLOW, 8'h00, 1'b0);
								end else begin
									size_acc = {size_acc[SIZE_BITS-5:0], nib};
									if (hex_prefix == PFX_ZERO) hex_prefix = PFX_NONE;
								end
							end else if ((c == CH_LOWER_X || c == CH_UPPER_X) &&
									hex_prefix == PFX_ZERO) begin
								hex_prefix = PFX_X;
							end else begin
								parse_state = ST_EXT;
							end
						end
					end
				end
			end
			ST_PAYLOAD: begin
				data_remaining = data_remaining - SIZE_BITS'(1);
				if (data_remaining == 0) begin
					parse_state = ST_TAIL;
					push_result(KIND_DATA, c, 1'b1);
				end else begin
					push_result(KIND_DATA, c, 1'b0);
				end
			end
			ST_TAIL: begin
				if (c == CH_LF) clear_size_line();
			end
			ST_TRAILER: begin
				if (c == CH_LF) begin
					if (!trailer_text) begin
						parse_state = ST_DONE;
						push_result(KIND_COMPLETE, 8'h00, 1'b0);
					end else begin
						trailer_text = 1'b0;
					end
				end else if (c != CH_CR) begin
					trailer_text = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function void put_byte(logic [7:0] value, logic start);
		body_byte_t b;
		b.value = value;
		b.start = start;
		stream.insert(stream.size(), b);
	endfunction

	function void put_text(input string text);
		for (int i = 0; i < text.len(); i++) put_byte(text[i], 1'b0);
	endfunction

	function logic [7:0] hex_char(logic [3:0] nib, logic upper);
		if (nib < 4'd10) return CH_ZERO + 8'(nib);
		return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	function logic [7:0] blank_char();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function logic [7:0] non_lf_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_LF) b = 8'($urandom_range(8'h20, 8'h7E));
		return b;
	endfunction

	function void put_size_line(logic [SIZE_BITS-1:0] size);
		int top;
		logic upper;
		upper = 1'($urandom_range(1));
		repeat ($urandom_range(2)) put_byte(blank_char(), 1'b0);
		if ($urandom_range(3) == 0) begin
			put_byte(CH_ZERO, 1'b0);
			put_byte(upper ? CH_UPPER_X : CH_LOWER_X, 1'b0);
		end
		repeat ($urandom_range(2)) put_byte(CH_ZERO, 1'b0);
		top = SIZE_BITS / 4 - 1;
		while (top > 0 && size[4*top +: 4] == 4'd0) top--;
		for (int i = top; i >= 0; i--) put_byte(hex_char(size[4*i +: 4], upper), 1'b0);
		if ($urandom_range(2) == 0) begin
			put_byte(CH_SEMI, 1'b0);
			repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
		end
		if ($urandom_range(1)) put_byte(CH_CR, 1'b0);
		put_byte(CH_LF, 1'b0);
	endfunction

	// Recovers the size just framed by put_size_line from the bytes in the stream.
	function logic [SIZE_BITS-1:0] chunk_len_of_last();
		int i;
		logic [SIZE_BITS-1:0] size;
		logic ok;
		logic [3:0] nib;
		logic seen_x;
		i = stream.size() - 2;
		while (i > 0 && stream[i].value != CH_LF) i--;
		if (stream[i].value == CH_LF) i++;
		size = '0;
		seen_x = 1'b0;
		while (stream[i].value == CH_SPACE || stream[i].value == CH_TAB ||
				stream[i].value == CH_VT || stream[i].value == CH_FF) i++;
		for (; i < stream.size(); i++) begin
			hex_digit(stream[i].value, ok, nib);
			if (ok) begin
				size = {size[SIZE_BITS-5:0], nib};
			end else if (!seen_x && size == 0 &&
					(stream[i].value == CH_LOWER_X || stream[i].value == CH_UPPER_X)) begin
				seen_x = 1'b1;
			end else begin
				break;
			end
		end
		return size;
	endfunction

	// Mostly well-formed bodies with random framing and payload; one in six is disturbed.
	function void gen_body();
		int first;
		int span;
		first = stream.size();
		repeat ($urandom_range(3)) begin
			put_size_line(($urandom_range(7) == 0) ? $urandom_range(13, 60)
				: $urandom_range(1, 12));
			for (int i = 0; i < int'(chunk_len_of_last()); i++)
				put_byte(8'($urandom_range(255)), 1'b0);
			repeat ($urandom_range(2)) put_byte(non_lf_byte(), 1'b0);
			if ($urandom_range(1)) put_byte(CH_CR, 1'b0);
			put_byte(CH_LF, 1'b0);
		end
		case ($urandom_range(4))
			0: put_text("\r\n");
			1: put_text("0x\n");
			default: put_size_line('0);
		endcase
		repeat ($urandom_range(2)) begin
			repeat ($urandom_range(1, 5)) put_byte(non_lf_byte(), 1'b0);
			put_text("\r\n");
		end
		if ($urandom_range(1)) put_byte(CH_CR, 1'b0);
		put_byte(CH_LF, 1'b0);
		stream[first].start = ($urandom_range(9) != 0);
		if ($urandom_range(5) == 0) begin
			span = stream.size() - first;
			case ($urandom_range(4))
				0: stream[first + $urandom_range(span - 1)].value = 8'($urandom_range(255));
				1: stream[first + $urandom_range(span - 1)].start = 1'b1;
				2: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(255)), 1'b0);
				3: begin
					put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))), 1'b1);
					repeat ($urandom_range(8, 10))
						put_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
				end
				default: begin
					put_byte(blank_char(), 1'b1);
					put_size_line(SIZE_BITS'($urandom()));
					repeat ($urandom_range(20)) put_byte(8'($urandom_range(255)), 1'b0);
				end
			endcase
		end
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic start);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= value;
		in_ch.start_body <= start;
		do @(posedge clk); while (!in_ch.ready);
		decode_byte(value, start);
		@(negedge clk);
	endtask

	task automatic send_stream();
		body_byte_t b;
		while (stream.size() != 0) begin
			b = stream.pop_front();
			send_byte(b.value, b.start);
		end
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			failures++;
			pending_results.delete();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_line_limit(input logic [CFG_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		line_limit = value;
	endtask

	task automatic test_framing();
		put_byte(CH_TAB, 1'b1);
		put_byte(CH_VT, 1'b0);
		put_byte(CH_FF, 1'b0);
		put_text(" 0X2;e\r\n");
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_text("z\n0x1x\r\nA\n0x\r\nt\n\r\nZ");
		send_stream();
		wait_drained();
	endtask

	task automatic test_size_errors();
		put_byte("f", 1'b1);
		put_text("ffffffF1");
		put_text("1\n");
		put_byte("F", 1'b1);
		put_text("FFFFFFF\n\r\n\r");
		put_byte("1", 1'b1);
		put_text("\nA\r\n0\n\n");
		send_stream();
		wait_drained();
	endtask

	task automatic test_line_limit();
		write_line_limit(12'd1);
		put_byte("1", 1'b1);
		put_text("\r\nQ\n12\n");
		put_byte(CH_CR, 1'b1);
		put_text("0\r\n\r\n");
		send_stream();
		write_line_limit(12'd9);
		put_byte("1", 1'b1);
		put_text("00000000");
		send_stream();
		write_line_limit(12'd8);
		put_byte("1", 1'b1);
		put_text("00000000");
		send_stream();
		write_line_limit(12'd200);
		put_byte("1", 1'b1);
		put_byte(CH_SEMI, 1'b0);
		repeat (198) put_byte("e", 1'b0);
		put_text("\r\nD\n0");
		repeat (200) put_byte("e", 1'b0);
		send_stream();
		wait_drained();
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		hold_request = 300;
		put_byte("2", 1'b1);
		put_text("0\n");
		repeat (32) put_byte(8'($urandom_range(255)), 1'b0);
		put_text("\r\n0\n\n");
		send_stream();
		wait_drained();
	endtask

	task automatic run_random_phase(input int src_pct, input int snk_pct,
			input logic [CFG_W-1:0] limit, input int n_bytes);
		int sent;
		sent = 0;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		write_line_limit(limit);
		while (sent < n_bytes) begin
			gen_body();
			sent += stream.size();
			send_stream();
		end
		wait_drained();
	endtask

	task automatic test_random_bodies();
		run_random_phase(26, 57, 12'd4095, 300);
		run_random_phase(57, 26, 12'd12, 300);
		run_random_phase(0, 0, 12'($urandom_range(13, 40)), 300);
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transfer: result_kind %0d data_byte %02h chunk_last %0b",
					out_ch.result_kind, out_ch.data_byte, out_ch.chunk_last);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, out_ch.result_kind);
					failures++;
				end
				if (out_ch.data_byte !== want.data_byte) begin
					$error("data_byte: expected %02h, got %02h", want.data_byte,
						out_ch.data_byte);
					failures++;
				end
				if (out_ch.chunk_last !== want.chunk_last) begin
					$error("chunk_last: expected %0b, got %0b", want.chunk_last,
						out_ch.chunk_last);
					failures++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.start_body = 1'b0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		reset_decoder_model();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_framing();
		test_size_errors();
		test_line_limit();
		test_backpressure();
		test_random_bodies();
		wait_drained();
		if (failures == 0) begin
			$display("[http_chunked_body_decoder_core] OK");
		end else begin
			$display("[http_chunked_body_decoder_core] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[http_chunked_body_decoder_core] ERROR");
		$finish;
	end

endmodule
